// File: hw/rtl/pdd_pkg.sv
`timescale 1ns / 1ps

package pdd_pkg;

    localparam int DATA_W     = 32;
    localparam int CW_W       = 5;
    localparam int CODE_W     = 31;
    localparam int STEP_W     = 48;
    localparam int ICNT_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam int STORE_W    = 63;
    localparam int HELD_W     = 6;
    localparam int NRES_W     = 6;
    localparam logic [NRES_W-1:0] MAX_RESULTS = 6'd32;

    localparam logic FUNC_REF  = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    localparam logic [CW_W-1:0] CW_RESET = 5'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODE_WIDTH = 2'd0,
        CFG_OFFSET     = 2'd1,
        CFG_STEP       = 2'd2,
        CFG_ITEM_COUNT = 2'd3
    } t_cfg_idx;

    // bit store controls
    typedef struct packed {
        logic clear;
        logic append;
        logic pop;
    } t_buf_ctl;

    // arithmetic unit controls
    typedef struct packed {
        logic load;
        logic capture;
        logic mul_lo;
        logic mul_hi;
        logic add_q;
        logic acc;
    } t_ar_ctl;

endpackage

// File: hw/rtl/pdd_if.sv
`timescale 1ns / 1ps

interface pdd_in_if
    import pdd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic [DATA_W-1:0] packed_word;
    logic [DATA_W-1:0] ref_value;

    modport source (output valid, output func, output packed_word, output ref_value,
                    input ready);
    modport sink   (input valid, input func, input packed_word, input ref_value,
                    output ready);
endinterface

interface pdd_out_if
    import pdd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] value;
    logic              last_of_word;
    logic              track_done;

    modport source (output valid, output value, output last_of_word, output track_done,
                    input ready);
    modport sink   (input valid, input value, input last_of_word, input track_done,
                    output ready);
endinterface

// File: hw/rtl/packed_delta_dequantizer_top.sv
`timescale 1ns / 1ps

// channel  | dir | handshake     | payload
// i_in     | in  | valid / ready | func, packed_word, ref_value
// o_out    | out | valid / ready | value, last_of_word, track_done
// i_cfg_*  | in  | write enable  | i_cfg_idx, i_cfg_data
//
// a reference word or a discarded data word is taken without leaving idle
// a data word yielding codes keeps ready low until its last code is accumulated: one shared
// 32x32 multiplier is used twice per code, then a rounding add and a
// saturating accumulate, four steps per code under the sequencer
// reset is synchronous, active low; no clearing pass is needed
// a result waiting in the output register stalls the accumulate step only

module packed_delta_dequantizer_top
    import pdd_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pdd_in_if.sink                i_in,
    pdd_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_MUL_LO,
        S_MUL_HI,
        S_ADDQ,
        S_ACC
    } t_state;

    // configuration registers
    logic [CW_W-1:0]   r_cfg_cw;
    logic [DATA_W-1:0] r_cfg_off;
    logic [STEP_W-1:0] r_cfg_step;
    logic [ICNT_W-1:0] r_cfg_cnt;

    // sequencer state
    t_state                r_state;
    logic [NRES_W-1:0]     r_n;
    logic [COUNT_BITS-1:0] r_cd;

    // output register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic              r_out_last;
    logic              r_out_done;

    logic                  in_acc;
    logic                  out_free;
    logic                  cont;
    logic                  over;
    logic [CW_W-1:0]       w_eff;
    logic [COUNT_BITS-1:0] limit;
    logic [CODE_W-1:0]     code;
    logic                  avail;
    logic [DATA_W-1:0]     acc_value;
    t_buf_ctl              buf_ctl;
    t_ar_ctl               ar_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cw   <= CW_RESET;
            r_cfg_off  <= '0;
            r_cfg_step <= '0;
            r_cfg_cnt  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CODE_WIDTH: r_cfg_cw   <= i_cfg_data[CW_W-1:0];
                CFG_OFFSET:     r_cfg_off  <= i_cfg_data[DATA_W-1:0];
                CFG_STEP:       r_cfg_step <= i_cfg_data[STEP_W-1:0];
                CFG_ITEM_COUNT: r_cfg_cnt  <= i_cfg_data[ICNT_W-1:0];
            endcase
        end
    end

    always_comb begin
        // width zero decodes as one bit
        w_eff    = (r_cfg_cw == '0) ? CW_W'(1) : r_cfg_cw;
        limit    = COUNT_BITS'(r_cfg_cnt);
        over     = (r_cd >= limit);
        in_acc   = i_in.valid && i_in.ready;
        out_free = !r_out_valid || o_out.ready;
        // another code follows in this word: room for results, bits, and count
        cont     = (r_n < MAX_RESULTS) && avail && !over;

        buf_ctl.clear  = in_acc && (i_in.func == FUNC_REF);
        buf_ctl.append = in_acc && (i_in.func == FUNC_DATA) && !over;
        buf_ctl.pop    = (r_state == S_HEAD) || ((r_state == S_ACC) && out_free && cont);

        ar_ctl.load    = buf_ctl.clear;
        ar_ctl.capture = buf_ctl.pop;
        ar_ctl.mul_lo  = (r_state == S_MUL_LO);
        ar_ctl.mul_hi  = (r_state == S_MUL_HI);
        ar_ctl.add_q   = (r_state == S_ADDQ);
        ar_ctl.acc     = (r_state == S_ACC) && out_free;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.value        = r_out_value;
    assign o_out.last_of_word = r_out_last;
    assign o_out.track_done   = r_out_done;

    pdd_bitbuf u_bitbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (buf_ctl),
        .i_width (w_eff),
        .i_word  (i_in.packed_word),
        .o_code  (code),
        .o_avail (avail)
    );

    pdd_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ar_ctl),
        .i_code   (code),
        .i_ref    (i_in.ref_value),
        .i_offset (r_cfg_off),
        .i_step   (r_cfg_step),
        .o_value  (acc_value)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= '0;
            r_cd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result replaces the one leaving in the same cycle
            if (ar_ctl.acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (buf_ctl.pop) begin
                r_n  <= r_n + NRES_W'(1);
                r_cd <= r_cd + COUNT_BITS'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (buf_ctl.clear) begin
                        r_cd <= '0;
                    end else if (buf_ctl.append) begin
                        r_n     <= '0;
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD:   r_state <= S_MUL_LO;
                S_MUL_LO: r_state <= S_MUL_HI;
                S_MUL_HI: r_state <= S_ADDQ;
                S_ADDQ:   r_state <= S_ACC;
                S_ACC: begin
                    if (out_free) begin
                        r_out_value <= acc_value;
                        r_out_last  <= !cont;
                        r_out_done  <= over;
                        r_state     <= cont ? S_MUL_LO : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // count never runs past the configured limit while a word is worked
    a_cd_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_cd <= limit))
        else $error("code count beyond limit");

    // no more than the allowed results per word
    a_res_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= MAX_RESULTS)
        else $error("too many results for one word");

    // the final code of a track always closes its word
    a_done_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> r_out_last)
        else $error("track done without last of word");

    // a popped code reaches the accumulate step by way of the MUL_LO, MUL_HI and ADDQ states
    a_pop_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_ctl.pop |-> ##4 (r_state == S_ACC))
        else $error("code pipeline out of step");

endmodule

// File: hw/rtl/pdd_bitbuf.sv
`timescale 1ns / 1ps

module pdd_bitbuf
    import pdd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_buf_ctl          i_ctl,
    input  logic [CW_W-1:0]   i_width,
    input  logic [DATA_W-1:0] i_word,
    output logic [CODE_W-1:0] o_code,
    output logic              o_avail
);

    logic [STORE_W-1:0] r_store;
    logic [HELD_W-1:0]  r_held;

    logic [CW_W-1:0]    held_lo;
    logic [STORE_W-1:0] keep_mask;
    logic [STORE_W-1:0] code_mask;

    always_comb begin
        held_lo   = r_held[CW_W-1:0];
        keep_mask = (STORE_W'(1) << held_lo) - STORE_W'(1);
        code_mask = (STORE_W'(1) << i_width) - STORE_W'(1);
        o_code    = CODE_W'(r_store & code_mask);
        o_avail   = (r_held >= HELD_W'(i_width));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
            r_held  <= '0;
        end else if (i_ctl.clear) begin
            r_store <= '0;
            r_held  <= '0;
        end else if (i_ctl.append) begin
            // new word goes above the bits still held (count taken mod 32)
            r_store <= (r_store & keep_mask) | (STORE_W'(i_word) << held_lo);
            r_held  <= {1'b1, held_lo};
        end else if (i_ctl.pop) begin
            r_store <= r_store >> i_width;
            r_held  <= r_held - HELD_W'(i_width);
        end
    end

endmodule

// File: hw/rtl/pdd_arith.sv
`timescale 1ns / 1ps

module pdd_arith
    import pdd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ar_ctl           i_ctl,
    input  logic [CODE_W-1:0] i_code,
    input  logic [DATA_W-1:0] i_ref,
    input  logic [DATA_W-1:0] i_offset,
    input  logic [STEP_W-1:0] i_step,
    output logic [DATA_W-1:0] o_value
);

    logic [STEP_W-1:0]   r_mag;
    logic                r_neg;
    logic [CODE_W-1:0]   r_code;
    logic [63:0]         r_prod;
    logic [31:0]         r_lornd;
    logic [62:0]         r_q;
    logic [DATA_W:0]     r_base;
    logic [DATA_W-1:0]   r_run;

    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [47:0]         lo_sum;
    logic [64:0]         q_ext;
    logic [64:0]         sum;
    logic                sat_hi;
    logic                sat_lo;

    always_comb begin
        mul_a  = {1'b0, r_code};
        mul_b  = i_ctl.mul_hi ? r_mag[47:16] : {16'b0, r_mag[15:0]};
        lo_sum = r_prod[47:0] + 48'h8000;
        q_ext  = {2'b00, r_q};
        sum    = {{32{r_base[DATA_W]}}, r_base} + (r_neg ? (~q_ext + 65'd1) : q_ext);
        sat_hi = !sum[64] && (sum[63:31] != '0);
        sat_lo = sum[64] && (sum[63:31] != '1);
        if (sat_hi) begin
            o_value = 32'h7FFF_FFFF;
        end else if (sat_lo) begin
            o_value = 32'h8000_0000;
        end else begin
            o_value = sum[31:0];
        end
    end

    // step magnitude and sign, settle while the block is idle
    always_ff @(posedge i_clk) begin
        r_neg <= i_step[STEP_W-1];
        r_mag <= i_step[STEP_W-1] ? (~i_step + STEP_W'(1)) : i_step;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_code <= i_code;
        end
        if (i_ctl.mul_lo || i_ctl.mul_hi) begin
            r_prod <= 64'(mul_a) * 64'(mul_b);
        end
        if (i_ctl.mul_hi) begin
            r_lornd <= lo_sum[47:16];
            r_base  <= {r_run[DATA_W-1], r_run} + {i_offset[DATA_W-1], i_offset};
        end
        if (i_ctl.add_q) begin
            r_q <= r_prod[62:0] + {31'b0, r_lornd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (i_ctl.load) begin
            r_run <= i_ref;
        end else if (i_ctl.acc) begin
            r_run <= o_value;
        end
    end

endmodule

// File: tb/sv/tb_packed_delta_dequantizer_top.sv
`timescale 1ns / 1ps

module tb_packed_delta_dequantizer_top;
    import pdd_pkg::*;

    localparam int          MAX_RES        = 32;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam longint      Q_MAX          = 64'sd2147483647;
    localparam longint      Q_MIN          = -64'sd2147483648;

    // one input word as offered to the block
    typedef struct {
        logic              func;
        logic [DATA_W-1:0] packed_word;
        logic [DATA_W-1:0] ref_value;
    } t_in_word;

    // one decoded running value as the block should emit it
    typedef struct {
        logic [DATA_W-1:0] value;
        logic              last_of_word;
        logic              track_done;
    } t_decoded;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    pdd_in_if  in_ch ();
    pdd_out_if out_ch ();

    packed_delta_dequantizer_top #(
        .COUNT_BITS (16)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // words waiting to be offered and running values still owed by the block
    t_in_word pending_words[$];
    t_decoded expected_values[$];

    // decoder copy: configuration registers
    logic [CW_W-1:0]   cf_width;
    logic [DATA_W-1:0] cf_offset;
    logic [STEP_W-1:0] cf_step;
    logic [ICNT_W-1:0] cf_count;

    // decoder copy: stream and accumulator state
    logic [63:0]       pr_store;
    int                pr_held;
    logic [ICNT_W-1:0] pr_done;
    logic [DATA_W-1:0] pr_run;

    // bookkeeping shared by the clocked processes
    int       n_issued = 0;
    int       n_acc = 0;
    int       n_err = 0;
    int       quiet_cycles = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    logic     in_took = 1'b0;
    t_in_word drv_word;
    t_decoded got_val;
    t_decoded want_val;

    // long receiver hold-off: armed by the stimulus, timed by the receiver
    logic     hold_go = 1'b0;
    logic     hold_taken = 1'b0;
    int       hold_left = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Q16.16 delta of one code: magnitude of code * step rounded to nearest,
    // ties away from zero, then the sign of the step applied
    function automatic longint code_to_delta(logic [63:0] code);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] q;
        neg = cf_step[STEP_W-1];
        mag = neg ? (64'h0001_0000_0000_0000 - {16'd0, cf_step}) : {16'd0, cf_step};
        hi  = mag >> 16;
        lo  = {48'd0, mag[15:0]};
        q   = code * hi + ((code * lo + 64'h8000) >> 16);
        return neg ? -$signed(q) : $signed(q);
    endfunction

    // decode one accepted input word and queue the running values it yields
    task automatic decode_word(logic func, logic [DATA_W-1:0] word, logic [DATA_W-1:0] refv);
        logic [ICNT_W-1:0] limit;
        int                w;
        int                n;
        logic [63:0]       mask;
        logic [63:0]       code;
        longint            sum;
        t_decoded          r;
        limit = cf_count;
        w     = (cf_width == 0) ? 1 : int'(cf_width);
        mask  = (64'd1 << w) - 64'd1;
        n     = 0;
        // reference word: load the accumulator and restart the stream
        if (func == FUNC_REF) begin
            pr_run   = refv;
            pr_store = '0;
            pr_held  = 0;
            pr_done  = '0;
            return;
        end
        // track already complete: the word is dropped
        if (pr_done >= limit) begin
            return;
        end
        // append the new word above the bits still held
        pr_held  = pr_held & 31;
        pr_store = (pr_store & ((64'd1 << pr_held) - 64'd1)) | ({32'd0, word} << pr_held);
        pr_held  = pr_held + 32;
        while (n < MAX_RES && pr_held >= w && pr_done < limit) begin
            code     = pr_store & mask;
            pr_store = pr_store >> w;
            pr_held  = pr_held - w;
            pr_done  = pr_done + 1'b1;
            sum = longint'($signed(pr_run)) + longint'($signed(cf_offset)) + code_to_delta(code);
            if (sum > Q_MAX) begin
                sum = Q_MAX;
            end
            if (sum < Q_MIN) begin
                sum = Q_MIN;
            end
            pr_run = sum[DATA_W-1:0];
            n++;
            r.value        = pr_run;
            r.track_done   = (pr_done >= limit);
            // last of the word when the loop is about to stop
            r.last_of_word = !(n < MAX_RES && pr_held >= w && pr_done < limit);
            expected_values.insert(expected_values.size(), r);
        end
    endtask

    // register write, mirrored into the decoder copy
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_CODE_WIDTH: begin
                cf_width = data[CW_W-1:0];
            end
            CFG_OFFSET: begin
                cf_offset = data[DATA_W-1:0];
            end
            CFG_STEP: begin
                cf_step = data[STEP_W-1:0];
            end
            default: begin
                cf_count = data[ICNT_W-1:0];
            end
        endcase
    endtask

    task automatic set_cfg(logic [CW_W-1:0] w, logic [DATA_W-1:0] off,
                           logic [STEP_W-1:0] stp, logic [ICNT_W-1:0] cnt);
        write_reg(CFG_CODE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_OFFSET, CFG_DATA_W'(off));
        write_reg(CFG_STEP, CFG_DATA_W'(stp));
        write_reg(CFG_ITEM_COUNT, CFG_DATA_W'(cnt));
    endtask

    task automatic push_word(logic func, logic [DATA_W-1:0] word, logic [DATA_W-1:0] refv);
        t_in_word t;
        t.func        = func;
        t.packed_word = word;
        t.ref_value   = refv;
        pending_words.insert(pending_words.size(), t);
    endtask

    // wait until every word is taken and every running value has come back,
    // then let the sequencer settle after words that yield nothing
    task automatic drain();
        while (pending_words.size() != 0 || n_acc != n_issued || expected_values.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // per-phase settings: mostly moderate, now and then the extremes
    task automatic random_config();
        logic [CW_W-1:0]   w;
        logic [DATA_W-1:0] off;
        logic [STEP_W-1:0] mag;
        logic [STEP_W-1:0] stp;
        logic [ICNT_W-1:0] cnt;
        case ($urandom_range(9))
            0:       w = 5'd1;
            1:       w = 5'd31;
            2:       w = 5'd0;
            3:       w = 5'd16;
            default: w = CW_W'($urandom_range(12, 2));
        endcase
        case ($urandom_range(7))
            0:       off = 32'h7FFF_FFFF;
            1:       off = 32'h8000_0000;
            2:       off = $urandom;
            default: off = $urandom_range(32'h0002_0000, 0) - 32'h0001_0000;
        endcase
        mag = {16'd0, 32'($urandom)} >> $urandom_range(31, 0);
        case ($urandom_range(7))
            0:       stp = 48'h7FFF_FFFF_FFFF;
            1:       stp = 48'h8000_0000_0000;
            2:       stp = {16'($urandom), 32'($urandom)};
            default: stp = ($urandom_range(1) != 0) ? -mag : mag;
        endcase
        case ($urandom_range(9))
            0:       cnt = 16'hFFFF;
            1:       cnt = 16'd1;
            default: cnt = ICNT_W'($urandom_range(48, 2));
        endcase
        set_cfg(w, off, stp, cnt);
    endtask

    // mostly whole tracks (reference plus the words it needs), some cut short,
    // some overrun, and a little noise in between
    task automatic random_phase(int unsigned quota);
        int unsigned counted;
        int unsigned w;
        int unsigned nwords;
        int unsigned k;
        counted = 0;
        w = (cf_width == 0) ? 1 : cf_width;
        while (counted < quota) begin
            if ($urandom_range(99) < 8) begin
                push_word($urandom_range(1), $urandom, $urandom);
            end else begin
                push_word(FUNC_REF, $urandom, $urandom);
                nwords = (cf_count * w + 31) / 32;
                if (nwords > 12) begin
                    nwords = $urandom_range(12, 1);
                end
                // broken track: stop early, the next reference restarts
                if ($urandom_range(9) == 0) begin
                    nwords = $urandom_range(nwords, 0);
                end
                for (k = 0; k < nwords; k++) begin
                    push_word(FUNC_DATA, $urandom, $urandom);
                end
                counted += 1 + nwords;
                // extra word past the end of the track
                if ($urandom_range(9) == 0) begin
                    push_word(FUNC_DATA, $urandom, $urandom);
                end
            end
        end
    endtask

    // sender: a new word goes out once the previous one was taken
    always @(negedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_took) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_word = pending_words.pop_front();
                n_issued++;
                in_ch.valid       <= 1'b1;
                in_ch.func        <= drv_word.func;
                in_ch.packed_word <= drv_word.packed_word;
                in_ch.ref_value   <= drv_word.ref_value;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off to back the block up
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_go && !hold_taken) begin
            out_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_taken   <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: check outgoing words, decode incoming words, watch for hangs
    always @(posedge clk) begin
        in_took <= in_ch.valid && in_ch.ready;
        if (rst_n) begin
            // results are checked before this edge's input is decoded
            if (out_ch.valid && out_ch.ready) begin
                got_val.value        = out_ch.value;
                got_val.last_of_word = out_ch.last_of_word;
                got_val.track_done   = out_ch.track_done;
                if (expected_values.size() == 0) begin
                    $display("%0t: unexpected word: value %h last_of_word %b track_done %b",
                             $time, got_val.value, got_val.last_of_word, got_val.track_done);
                    n_err++;
                end else begin
                    want_val = expected_values.pop_front();
                    if (got_val.value !== want_val.value) begin
                        $display("%0t: value mismatch: expected %h actual %h",
                                 $time, want_val.value, got_val.value);
                        n_err++;
                    end
                    if (got_val.last_of_word !== want_val.last_of_word) begin
                        $display("%0t: last_of_word mismatch: expected %b actual %b",
                                 $time, want_val.last_of_word, got_val.last_of_word);
                        n_err++;
                    end
                    if (got_val.track_done !== want_val.track_done) begin
                        $display("%0t: track_done mismatch: expected %b actual %b",
                                 $time, want_val.track_done, got_val.track_done);
                        n_err++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                decode_word(in_ch.func, in_ch.packed_word, in_ch.ref_value);
                n_acc++;
            end
            // watchdog on cycles where no word moves on either side
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog: no word moved for %0d cycles", $time, quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int p;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.func        = FUNC_REF;
        in_ch.packed_word = '0;
        in_ch.ref_value   = '0;
        out_ch.ready      = 1'b0;
        // decoder copy starts from the reset values
        cf_width  = CW_RESET;
        cf_offset = '0;
        cf_step   = '0;
        cf_count  = '0;
        pr_store  = '0;
        pr_held   = 0;
        pr_done   = '0;
        pr_run    = '0;
        set_idling(0, 0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // count of zero after reset: data words are dropped, even after a reference
        push_word(FUNC_DATA, 32'hFFFF_FFFF, 32'h0000_0000);
        push_word(FUNC_REF, 32'h0000_0000, 32'h1234_5678);
        push_word(FUNC_DATA, 32'hA5A5_A5A5, 32'h0000_0000);
        drain();

        // widest codes straddling words, largest offset and step: clamps high
        set_cfg(5'd31, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 16'hFFFF);
        push_word(FUNC_REF, 32'h0000_0000, 32'h8000_0000);
        push_word(FUNC_DATA, 32'hFFFF_FFFF, 32'h0000_0000);
        push_word(FUNC_DATA, 32'h0000_0000, 32'hFFFF_FFFF);
        push_word(FUNC_DATA, 32'hFFFF_FFFF, 32'h0000_0000);
        drain();

        // one-bit codes, most negative offset and step: clamps low, track ends
        // mid-word and the word after it is dropped
        set_cfg(5'd1, 32'h8000_0000, 48'h8000_0000_0000, 16'd40);
        push_word(FUNC_REF, 32'h0000_0000, 32'h7FFF_FFFF);
        push_word(FUNC_DATA, 32'hAAAA_AAAA, 32'h0000_0000);
        push_word(FUNC_DATA, 32'h5555_5555, 32'h0000_0000);
        push_word(FUNC_DATA, 32'hFFFF_FFFF, 32'h0000_0000);
        drain();

        // width of zero acts as one; negative step with a rounding tie;
        // leftover bits vanish at the next reference
        set_cfg(5'd0, 32'h0000_0000, 48'hFFFF_FFFF_8000, 16'd5);
        push_word(FUNC_REF, 32'h0000_0000, 32'h0000_0000);
        push_word(FUNC_DATA, 32'h0000_001D, 32'h0000_0000);
        push_word(FUNC_REF, 32'h0000_0000, 32'h0001_0000);
        push_word(FUNC_DATA, 32'hFFFF_FFFF, 32'h0000_0000);
        drain();

        // width shrinks mid-track: more whole codes than one word may emit,
        // the rest carry over to the next word
        set_cfg(5'd20, 32'hFFFF_0000, 48'h0001_0000_8000, 16'd100);
        push_word(FUNC_REF, 32'h0000_0000, 32'h0000_0000);
        push_word(FUNC_DATA, 32'hDEAD_BEEF, 32'h0000_0000);
        push_word(FUNC_DATA, 32'h0BAD_F00D, 32'h0000_0000);
        drain();
        write_reg(CFG_CODE_WIDTH, CFG_DATA_W'(1));
        push_word(FUNC_DATA, 32'h1357_9BDF, 32'h0000_0000);
        push_word(FUNC_DATA, 32'h2468_ACE0, 32'h0000_0000);
        push_word(FUNC_REF, 32'h0000_0000, 32'h0000_8000);
        push_word(FUNC_DATA, 32'hFFFF_FFFF, 32'h0000_0000);
        drain();

        // random phases, cycling the idling patterns
        for (p = 0; p < 10; p++) begin
            random_config();
            case (p % 4)
                0:       set_idling(0, 0);
                1:       set_idling(84, 0);
                2:       set_idling(0, 84);
                default: set_idling(12, 12);
            endcase
            // first phase: receiver backs off long while words keep coming
            if (p == 0) begin
                hold_go = 1'b1;
            end
            random_phase(50);
            drain();
        end

        if (n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
